/* design/point_in_convex_polygon_3d_assert.svh */
// assertion macros shared by the queue and back-end design files
`ifndef POINT_IN_CONVEX_POLYGON_3D_ASSERT_SVH
`define POINT_IN_CONVEX_POLYGON_3D_ASSERT_SVH
`ifndef SYNTHESIS
`define PIC3D_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pic3d assertion failed: %m");
`define PIC3D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pic3d assertion failed: %m");
`else
`define PIC3D_ASSERT_SAME(lbl, ante, cons)
`define PIC3D_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/pic3d_pkg.sv */
package pic3d_pkg;

    localparam int COORD_BITS = 20;
    // edge and point differences
    localparam int DIFF_W = COORD_BITS + 1;
    // cross product components
    localparam int CROSS_W = 2 * DIFF_W + 1;
    // cross components are split into a signed high and unsigned low half for the dot
    localparam int LO_W = (CROSS_W + 1) / 2;
    localparam int HI_W = CROSS_W - LO_W;
    localparam int MUL_W = LO_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    // exact dot product, sum of three full products
    localparam int ACC_W = 2 * CROSS_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_POINT = 1'b0;
    localparam logic FUNC_VERTEX = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        CMD_POINT,
        CMD_START,
        CMD_SECOND,
        CMD_NEXT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      last;
        coord_t    x;
        coord_t    y;
        coord_t    z;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIFF,
        B_XMUL,
        B_XSUB,
        B_DMUL0,
        B_DMUL1,
        B_DACC0,
        B_DACC1,
        B_DSUM0,
        B_DSUM1,
        B_ADV,
        B_EMIT
    } back_state_t;

endpackage

/* design/pic3d_front.sv */
module pic3d_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic                                  func,
    input  logic signed [pic3d_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pic3d_pkg::COORD_BITS-1:0] coord_y,
    input  logic signed [pic3d_pkg::COORD_BITS-1:0] coord_z,
    input  logic                                  last_vertex,
    input  pic3d_pkg::queue_stat_t                qstat,
    output logic                                  push,
    output pic3d_pkg::cmd_t                       push_cmd
);

    // vertices seen in the current face, saturating at two
    logic [1:0] vcnt_reg, vcnt_next;

    assign req_ready = !qstat.full;
    assign push      = req_valid && req_ready;

    always_comb
    begin
        push_cmd.x    = coord_x;
        push_cmd.y    = coord_y;
        push_cmd.z    = coord_z;
        push_cmd.last = last_vertex && (func == pic3d_pkg::FUNC_VERTEX);
        if (func == pic3d_pkg::FUNC_POINT)
            push_cmd.kind = pic3d_pkg::CMD_POINT;
        else if (vcnt_reg == 2'd0)
            push_cmd.kind = pic3d_pkg::CMD_START;
        else if (vcnt_reg == 2'd1)
            push_cmd.kind = pic3d_pkg::CMD_SECOND;
        else
            push_cmd.kind = pic3d_pkg::CMD_NEXT;

        vcnt_next = vcnt_reg;
        if (push)
        begin
            if (func == pic3d_pkg::FUNC_POINT || last_vertex)
                vcnt_next = 2'd0;
            else if (vcnt_reg == 2'd0)
                vcnt_next = 2'd1;
            else
                vcnt_next = 2'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcnt_reg <= 2'd0;
        else
            vcnt_reg <= vcnt_next;
    end

endmodule

/* design/pic3d_queue.sv */
`include "point_in_convex_polygon_3d_assert.svh"

module pic3d_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pic3d_pkg::cmd_t        push_cmd,
    input  logic                   pop,
    output pic3d_pkg::cmd_t        pop_cmd,
    output pic3d_pkg::queue_stat_t stat
);

    pic3d_pkg::cmd_t                  slot_reg [pic3d_pkg::QUEUE_DEPTH];
    logic [pic3d_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [pic3d_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [pic3d_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == pic3d_pkg::QCNT_W'(pic3d_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            if (wr_ptr_reg == pic3d_pkg::QPTR_W'(pic3d_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == pic3d_pkg::QPTR_W'(pic3d_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    `PIC3D_ASSERT_SAME(a_no_push_when_full, push, !stat.full)
    `PIC3D_ASSERT_NEXT(a_cnt_grows, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

/* design/pic3d_back.sv */
`include "point_in_convex_polygon_3d_assert.svh"

module pic3d_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pic3d_pkg::cmd_t        cmd,
    input  pic3d_pkg::queue_stat_t qstat,
    output logic                   pop,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic                   inside_res,
    output logic                   malformed
);

    localparam int CW = pic3d_pkg::COORD_BITS;
    localparam int DW = pic3d_pkg::DIFF_W;
    localparam int XW = pic3d_pkg::CROSS_W;
    localparam int LW = pic3d_pkg::LO_W;
    localparam int MW = pic3d_pkg::MUL_W;
    localparam int PW = pic3d_pkg::PROD_W;
    localparam int AW = pic3d_pkg::ACC_W;

    pic3d_pkg::back_state_t state_reg, state_next;

    logic signed [CW-1:0] query_reg [3];
    logic signed [CW-1:0] first_reg [3];
    logic signed [CW-1:0] prev_reg [3];
    logic signed [CW-1:0] from_reg [3];
    logic signed [CW-1:0] to_reg [3];
    logic signed [CW-1:0] vtx [3];
    logic signed [DW-1:0] e_reg [3];
    logic signed [DW-1:0] q_reg [3];
    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];
    logic signed [PW-1:0] prod_a [3];
    logic signed [PW-1:0] prod_b [3];
    logic signed [XW-1:0] cross_reg [3];
    logic signed [XW-1:0] pcross_reg [3];
    logic signed [AW-1:0] acc_reg [3];
    logic signed [AW-1:0] sum_reg;
    logic signed [AW-1:0] dot_sum;

    logic cur_last_reg;
    logic closing_reg;
    logic dot_reg;
    logic outside_reg;
    logic bad_reg;
    logic res_valid_reg;
    logic res_inside_reg;
    logic res_malformed_reg;
    logic res_load;
    logic start_closing;

    function automatic logic signed [MW-1:0] hi_part(input logic signed [XW-1:0] v);
        return MW'($signed(v[XW-1:LW]));
    endfunction

    function automatic logic signed [MW-1:0] lo_part(input logic signed [XW-1:0] v);
        return $signed({1'b0, v[LW-1:0]});
    endfunction

    assign vtx[0] = cmd.x;
    assign vtx[1] = cmd.y;
    assign vtx[2] = cmd.z;

    assign dot_sum       = sum_reg + acc_reg[2];
    assign start_closing = (state_reg == pic3d_pkg::B_ADV) && !closing_reg && cur_last_reg;

    // one lane per component, two multipliers each, shared by cross and dot steps
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        logic signed [MW-1:0] a_a, a_b, b_a, b_b;

        always_comb
        begin
            unique case (state_reg)
                pic3d_pkg::B_XMUL:
                begin
                    a_a = MW'(e_reg[J]);
                    a_b = MW'(q_reg[K]);
                    b_a = MW'(e_reg[K]);
                    b_b = MW'(q_reg[J]);
                end
                pic3d_pkg::B_DMUL0:
                begin
                    a_a = hi_part(cross_reg[g]);
                    a_b = hi_part(pcross_reg[g]);
                    b_a = lo_part(cross_reg[g]);
                    b_b = lo_part(pcross_reg[g]);
                end
                pic3d_pkg::B_DMUL1:
                begin
                    a_a = hi_part(cross_reg[g]);
                    a_b = lo_part(pcross_reg[g]);
                    b_a = lo_part(cross_reg[g]);
                    b_b = hi_part(pcross_reg[g]);
                end
                default:
                begin
                    a_a = '0;
                    a_b = '0;
                    b_a = '0;
                    b_b = '0;
                end
            endcase
        end

        assign prod_a[g] = a_a * a_b;
        assign prod_b[g] = b_a * b_b;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pic3d_pkg::B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    unique case (cmd.kind)
                        pic3d_pkg::CMD_POINT:
                            state_next = pic3d_pkg::B_IDLE;
                        pic3d_pkg::CMD_START:
                            state_next = cmd.last ? pic3d_pkg::B_EMIT : pic3d_pkg::B_IDLE;
                        default:
                            state_next = pic3d_pkg::B_DIFF;
                    endcase
                end
            end
            pic3d_pkg::B_DIFF:  state_next = pic3d_pkg::B_XMUL;
            pic3d_pkg::B_XMUL:  state_next = pic3d_pkg::B_XSUB;
            pic3d_pkg::B_XSUB:  state_next = dot_reg ? pic3d_pkg::B_DMUL0 : pic3d_pkg::B_ADV;
            pic3d_pkg::B_DMUL0: state_next = pic3d_pkg::B_DMUL1;
            pic3d_pkg::B_DMUL1: state_next = pic3d_pkg::B_DACC0;
            pic3d_pkg::B_DACC0: state_next = pic3d_pkg::B_DACC1;
            pic3d_pkg::B_DACC1: state_next = pic3d_pkg::B_DSUM0;
            pic3d_pkg::B_DSUM0: state_next = pic3d_pkg::B_DSUM1;
            pic3d_pkg::B_DSUM1: state_next = pic3d_pkg::B_ADV;
            pic3d_pkg::B_ADV:
            begin
                if (closing_reg)
                    state_next = pic3d_pkg::B_EMIT;
                else if (cur_last_reg)
                    state_next = pic3d_pkg::B_DIFF;
                else
                    state_next = pic3d_pkg::B_IDLE;
            end
            pic3d_pkg::B_EMIT:
            begin
                if (res_load)
                    state_next = pic3d_pkg::B_IDLE;
            end
            default: state_next = pic3d_pkg::B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop      = (state_reg == pic3d_pkg::B_IDLE) && !qstat.empty;
        res_load = (state_reg == pic3d_pkg::B_EMIT) && (!res_valid_reg || res_ready);
    end

    assign res_valid  = res_valid_reg;
    assign inside_res = res_inside_reg;
    assign malformed  = res_malformed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pic3d_pkg::B_IDLE;
            cur_last_reg  <= 1'b0;
            closing_reg   <= 1'b0;
            dot_reg       <= 1'b0;
            outside_reg   <= 1'b0;
            bad_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                query_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                cur_last_reg <= cmd.last;
                closing_reg  <= 1'b0;
                dot_reg      <= (cmd.kind == pic3d_pkg::CMD_NEXT);
                bad_reg      <= (cmd.kind == pic3d_pkg::CMD_START) && cmd.last;
                if (cmd.kind == pic3d_pkg::CMD_POINT)
                begin
                    outside_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                        query_reg[i] <= vtx[i];
                end
            end
            if (start_closing)
            begin
                closing_reg <= 1'b1;
                dot_reg     <= 1'b1;
            end
            if (state_reg == pic3d_pkg::B_DSUM1 && dot_sum[AW-1])
                outside_reg <= 1'b1;
            if (res_load)
            begin
                outside_reg   <= 1'b0;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && cmd.kind == pic3d_pkg::CMD_START)
        begin
            for (int i = 0; i < 3; i++)
            begin
                first_reg[i] <= vtx[i];
                prev_reg[i]  <= vtx[i];
            end
        end
        if (pop && (cmd.kind == pic3d_pkg::CMD_SECOND || cmd.kind == pic3d_pkg::CMD_NEXT))
        begin
            for (int i = 0; i < 3; i++)
            begin
                from_reg[i] <= prev_reg[i];
                to_reg[i]   <= vtx[i];
                prev_reg[i] <= vtx[i];
            end
        end
        if (start_closing)
        begin
            // closing edge runs from the last vertex back to the first
            for (int i = 0; i < 3; i++)
            begin
                from_reg[i] <= to_reg[i];
                to_reg[i]   <= first_reg[i];
            end
        end
        if (state_reg == pic3d_pkg::B_DIFF)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i] <= DW'(to_reg[i]) - DW'(from_reg[i]);
                q_reg[i] <= DW'(query_reg[i]) - DW'(from_reg[i]);
            end
        end
        if (state_reg == pic3d_pkg::B_XMUL || state_reg == pic3d_pkg::B_DMUL0
            || state_reg == pic3d_pkg::B_DMUL1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= prod_a[i];
                pb_reg[i] <= prod_b[i];
            end
        end
        if (state_reg == pic3d_pkg::B_XSUB)
        begin
            for (int i = 0; i < 3; i++)
                cross_reg[i] <= XW'(pa_reg[i] - pb_reg[i]);
        end
        if (state_reg == pic3d_pkg::B_DMUL1)
        begin
            // high by high and low by low products do not overlap
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= $signed({pa_reg[i][AW-2*LW-1:0], pb_reg[i][2*LW-1:0]});
        end
        if (state_reg == pic3d_pkg::B_DACC0)
        begin
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= acc_reg[i] + (AW'(pa_reg[i]) <<< LW);
        end
        if (state_reg == pic3d_pkg::B_DACC1)
        begin
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= acc_reg[i] + (AW'(pb_reg[i]) <<< LW);
        end
        if (state_reg == pic3d_pkg::B_DSUM0)
            sum_reg <= acc_reg[0] + acc_reg[1];
        if (state_reg == pic3d_pkg::B_ADV)
        begin
            for (int i = 0; i < 3; i++)
                pcross_reg[i] <= cross_reg[i];
        end
        if (res_load)
        begin
            res_inside_reg    <= !outside_reg && !bad_reg;
            res_malformed_reg <= bad_reg;
        end
    end

    `PIC3D_ASSERT_NEXT(a_emit_shows_result, state_reg == pic3d_pkg::B_EMIT && res_load, res_valid)
    `PIC3D_ASSERT_SAME(a_flags_exclusive, res_valid, !(inside_res && malformed))
    `PIC3D_ASSERT_SAME(a_closing_on_last, closing_reg, cur_last_reg)

endmodule

/* design/point_in_convex_polygon_3d.sv */
// Point in convex polygon test on 20-bit signed millimetre coordinates. An item with func
// low loads the query point and restarts the face; items with func high stream the face
// vertices, and the one with last_vertex high closes the face and gives one result
// (inside_res, or malformed for a face of one vertex). Edge crosses and their dot with the
// previous edge's cross are computed exactly. A front end classifies items into a two-entry
// queue, so input transfers continue while the back end works. The back end's edge
// sequencer, three lanes of two 23x23 multipliers shared between cross and dot steps, sets
// the rate: a point load or first vertex passes only idle, a second vertex the difference
// and cross steps, each later vertex the dot steps too, and a last vertex the closing edge and
// result hand-off to the output register. After reset the query point is at the origin.
module point_in_convex_polygon_3d (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic                                  func,
    input  logic signed [pic3d_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pic3d_pkg::COORD_BITS-1:0] coord_y,
    input  logic signed [pic3d_pkg::COORD_BITS-1:0] coord_z,
    input  logic                                  last_vertex,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic                                  inside_res,
    output logic                                  malformed
);

    pic3d_pkg::queue_stat_t qstat;
    pic3d_pkg::cmd_t        push_cmd;
    pic3d_pkg::cmd_t        pop_cmd;
    logic                   push;
    logic                   pop;

    pic3d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .last_vertex (last_vertex),
        .qstat       (qstat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    pic3d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (qstat)
    );

    pic3d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (pop_cmd),
        .qstat      (qstat),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .inside_res (inside_res),
        .malformed  (malformed)
    );

endmodule

/* dv/point_in_convex_polygon_3d_tb.sv */
`timescale 1ns / 100ps

module point_in_convex_polygon_3d_tb;

    localparam int CMAX = 524287;
    localparam int CMIN = -524288;
    localparam int RANDOM_ITEMS = 1100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int HOLD_OFF_AT = 2500;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [pic3d_pkg::DIFF_W-1:0] diff_t;
    typedef logic signed [pic3d_pkg::CROSS_W-1:0] cross_t;
    typedef logic signed [pic3d_pkg::ACC_W-1:0] acc_t;

    typedef struct packed {
        pic3d_pkg::coord_t x;
        pic3d_pkg::coord_t y;
        pic3d_pkg::coord_t z;
    } point_t;

    typedef struct packed {
        cross_t x;
        cross_t y;
        cross_t z;
    } cross_vec_t;

    typedef struct packed {
        logic in_face;
        logic malformed;
    } face_res_t;

    // typed rows carry their verdict in ins/mal, the rest go through the predictor
    typedef struct packed {
        logic              f;
        pic3d_pkg::coord_t x;
        pic3d_pkg::coord_t y;
        pic3d_pkg::coord_t z;
        logic              lst;
        logic              typed;
        logic              ins;
        logic              mal;
    } stim_t;

    localparam int DIR_N = 24;
    localparam stim_t DIR_ROWS [DIR_N] = '{
        // lone vertex straight after reset
        '{pic3d_pkg::FUNC_VERTEX, 0, 0, 0, 1'b1, 1'b1, 1'b0, 1'b1},
        // point load with last set, which is ignored
        '{pic3d_pkg::FUNC_POINT, CMAX, CMAX, CMAX, 1'b1, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, CMIN, CMIN, CMIN, 1'b1, 1'b1, 1'b0, 1'b1},
        // origin inside a triangle
        '{pic3d_pkg::FUNC_POINT, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, -100, -100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, 100, -100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, 0, 100, 0, 1'b1, 1'b1, 1'b1, 1'b0},
        // same triangle, point outside
        '{pic3d_pkg::FUNC_POINT, 1000, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, -100, -100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, 100, -100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, 0, 100, 0, 1'b1, 1'b1, 1'b0, 1'b0},
        // point on a vertex, zero dots count as inside
        '{pic3d_pkg::FUNC_POINT, 100, -100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, -100, -100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, 100, -100, 0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, 0, 100, 0, 1'b1, 1'b1, 1'b1, 1'b0},
        // two-vertex face at the extremes
        '{pic3d_pkg::FUNC_POINT, CMIN, CMIN, CMIN, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, CMAX, CMIN, CMAX, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, CMIN, CMAX, CMIN, 1'b1, 1'b0, 1'b0, 1'b0},
        // face cut short by a point load
        '{pic3d_pkg::FUNC_VERTEX, CMAX, CMAX, CMIN, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, CMIN, CMAX, CMAX, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_POINT, 5, -7, 3, 1'b1, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, CMAX, 0, CMIN, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, 0, CMAX, CMAX, 1'b0, 1'b0, 1'b0, 1'b0},
        '{pic3d_pkg::FUNC_VERTEX, CMIN, CMIN, 0, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    // convex octagon outline, walked in order to build faces
    localparam int OCT_A [8] = '{3, 1, -1, -3, -3, -1, 1, 3};
    localparam int OCT_B [8] = '{1, 3, 3, 1, -1, -3, -3, -1};

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    logic              func;
    pic3d_pkg::coord_t coord_x;
    pic3d_pkg::coord_t coord_y;
    pic3d_pkg::coord_t coord_z;
    logic              last_vertex;
    logic              res_valid;
    logic              res_ready;
    logic              inside_res;
    logic              malformed;

    point_in_convex_polygon_3d dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .last_vertex (last_vertex),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .inside_res  (inside_res),
        .malformed   (malformed)
    );

    stim_t      stim_q [$];
    face_res_t  verdict_q [$];
    int         n_in;
    int         errors;
    int         idle_cycles;

    // face tracker state
    point_t     query_pt;
    point_t     first_v;
    point_t     prev_v;
    cross_vec_t prev_c;
    int         vert_cnt;
    logic       outside_seen;

    task automatic flag_error(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic cross_vec_t edge_cross(input point_t from, input point_t to);
        diff_t      e0, e1, e2, q0, q1, q2;
        cross_vec_t c;
        e0 = to.x - from.x;
        e1 = to.y - from.y;
        e2 = to.z - from.z;
        q0 = query_pt.x - from.x;
        q1 = query_pt.y - from.y;
        q2 = query_pt.z - from.z;
        c.x = e1 * q2 - e2 * q1;
        c.y = e2 * q0 - e0 * q2;
        c.z = e0 * q1 - e1 * q0;
        return c;
    endfunction

    function automatic logic dot_below_zero(input cross_vec_t a, input cross_vec_t b);
        acc_t s;
        s = a.x * b.x + a.y * b.y + a.z * b.z;
        return s[pic3d_pkg::ACC_W-1];
    endfunction

    function automatic bit face_step(input point_t v, input logic f, input logic lst,
                                     output face_res_t r);
        cross_vec_t c;
        r = '0;
        if (f == pic3d_pkg::FUNC_POINT)
        begin
            query_pt = v;
            vert_cnt = 0;
            outside_seen = 1'b0;
            return 1'b0;
        end
        if (vert_cnt == 0)
        begin
            first_v = v;
            prev_v = v;
            vert_cnt = 1;
            if (lst)
            begin
                r.in_face = 1'b0;
                r.malformed = 1'b1;
                vert_cnt = 0;
                outside_seen = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        end
        c = edge_cross(prev_v, v);
        if (vert_cnt >= 2 && dot_below_zero(c, prev_c))
            outside_seen = 1'b1;
        prev_c = c;
        prev_v = v;
        vert_cnt = 2;
        if (!lst)
            return 1'b0;
        // closing edge back to the first vertex
        c = edge_cross(prev_v, first_v);
        if (dot_below_zero(c, prev_c))
            outside_seen = 1'b1;
        prev_c = c;
        r.in_face = !outside_seen;
        r.malformed = 1'b0;
        vert_cnt = 0;
        outside_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int rand_small(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic push_item(input logic f, input int x, input int y, input int z,
                             input logic lst);
        stim_t it;
        it = '0;
        it.f = f;
        it.x = x;
        it.y = y;
        it.z = z;
        it.lst = lst;
        stim_q.push_back(it);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        query_pt = '0;
        first_v = '0;
        prev_v = '0;
        prev_c = '0;
        vert_cnt = 0;
        outside_seen = 1'b0;
        n_in = 0;
        errors = 0;
        idle_cycles = 0;
    end

    // stimulus build and input side
    initial
    begin
        int   gap, r, k, start, step, idx, j, a, b;
        int   cx, cy, cz, ux, uy, uz, wx, wy, wz, s, nx, ny, nz;
        logic calm;
        req_valid = 1'b0;
        func = pic3d_pkg::FUNC_POINT;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        last_vertex = 1'b0;

        for (int i = 0; i < DIR_N; i++)
            stim_q.push_back(DIR_ROWS[i]);

        while (stim_q.size() < DIR_N + RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                // planar convex face around a random center
                cx = rand_small(300000);
                cy = rand_small(300000);
                cz = rand_small(300000);
                ux = rand_small(8);
                uy = rand_small(8);
                uz = rand_small(8);
                wx = rand_small(8);
                wy = rand_small(8);
                wz = rand_small(8);
                s = ($urandom_range(9) == 0) ? $urandom_range(2000, 1) : $urandom_range(40, 1);
                if ($urandom_range(7) != 0)
                begin
                    a = rand_small(4);
                    b = rand_small(4);
                    nx = ($urandom_range(3) == 0) ? rand_small(2) : 0;
                    ny = ($urandom_range(3) == 0) ? rand_small(2) : 0;
                    nz = ($urandom_range(3) == 0) ? rand_small(2) : 0;
                    push_item(pic3d_pkg::FUNC_POINT, cx + s * (a * ux + b * wx) + nx,
                              cy + s * (a * uy + b * wy) + ny,
                              cz + s * (a * uz + b * wz) + nz, $urandom_range(1));
                end
                k = ($urandom_range(11) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
                start = $urandom_range(7);
                step = $urandom_range(1) ? 1 : 7;
                for (j = 0; j < k; j++)
                begin
                    idx = (start + step * j) % 8;
                    push_item(pic3d_pkg::FUNC_VERTEX,
                              cx + s * (OCT_A[idx] * ux + OCT_B[idx] * wx),
                              cy + s * (OCT_A[idx] * uy + OCT_B[idx] * wy),
                              cz + s * (OCT_A[idx] * uz + OCT_B[idx] * wz), j == k - 1);
                end
            end
            else if (r < 85)
            begin
                // full-range face, mostly non-convex or non-planar
                if ($urandom_range(1))
                    push_item(pic3d_pkg::FUNC_POINT, $urandom, $urandom, $urandom,
                              $urandom_range(1));
                k = $urandom_range(6, 1);
                for (j = 0; j < k; j++)
                    push_item(pic3d_pkg::FUNC_VERTEX, $urandom, $urandom, $urandom,
                              j == k - 1);
            end
            else
            begin
                k = $urandom_range(4, 1);
                for (j = 0; j < k; j++)
                    push_item($urandom_range(1), $urandom, $urandom, $urandom,
                              $urandom_range(1));
            end
        end

        wait (rst_n === 1'b1);
        @(posedge clk);
        for (int i = 0; i < stim_q.size(); i++)
        begin
            calm = ((i / 100) % 6) == 5;
            gap = calm ? 0 : pick_gap();
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req_valid <= 1'b1;
            func <= stim_q[i].f;
            coord_x <= stim_q[i].x;
            coord_y <= stim_q[i].y;
            coord_z <= stim_q[i].z;
            last_vertex <= stim_q[i].lst;
            @(posedge clk);
            while (!req_ready)
                @(posedge clk);
        end
        req_valid <= 1'b0;

        while (verdict_q.size() != 0 || n_in < stim_q.size())
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdict_q.size() != 0)
            flag_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
        if (errors == 0)
            $display("[point_in_convex_polygon_3d] OK");
        else
            $display("[point_in_convex_polygon_3d] ERROR");
        $finish;
    end

    // result side, with one long hold-off so the block backs up
    initial
    begin
        int   hold, sink_cyc;
        logic calm;
        hold = 0;
        sink_cyc = 0;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            sink_cyc++;
            calm = ((sink_cyc / 800) % 5) == 4;
            if (sink_cyc == HOLD_OFF_AT)
                hold = HOLD_OFF_CYCLES;
            if (hold > 0)
            begin
                res_ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_ready <= 1'b1;
                if (!calm && $urandom_range(3) == 0)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        point_t    pt;
        face_res_t want;
        logic      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                moved = 1'b1;
                if (verdict_q.size() == 0)
                begin
                    flag_error($sformatf("result inside=%0b malformed=%0b with none pending",
                                         inside_res, malformed));
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (inside_res !== want.in_face)
                        flag_error($sformatf("inside_res got %0b want %0b",
                                             inside_res, want.in_face));
                    if (malformed !== want.malformed)
                        flag_error($sformatf("malformed got %0b want %0b",
                                             malformed, want.malformed));
                end
            end
            if (req_valid && req_ready)
            begin
                moved = 1'b1;
                pt.x = coord_x;
                pt.y = coord_y;
                pt.z = coord_z;
                if (face_step(pt, func, last_vertex, want))
                begin
                    if (stim_q[n_in].typed)
                    begin
                        want.in_face = stim_q[n_in].ins;
                        want.malformed = stim_q[n_in].mal;
                    end
                    verdict_q.push_back(want);
                end
                n_in++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[point_in_convex_polygon_3d] ERROR");
                $finish;
            end
        end
    end

endmodule
